>>> src/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// Shared-buffer multi-queue package
// Store dimensions, pointer type and the status codes carried with each beat.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int MAX_QUEUES  = 8;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int WORD_W      = 32;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        status_t;

  localparam ptr_t NONE_PTR = ptr_t'(STORE_DEPTH);

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

endpackage

>>> src/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// Shared-buffer multi-queue
// The accepted beat is captured into the execute-state registers; the result
// beat is registered from them once no earlier result beat is still stalled.
// Input stalls while an item executes, so a new item waits for the last one;
// the next-link memory is read on accept and written back on execute.
// Reset: all queues empty, free list restored through per-entry link valid
// bits; there is no clearing pass. The register resets to 8.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue
  import sbmq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [2:0]         queue_number,
  input  logic signed [31:0] value_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value_out,
  output logic [1:0]         status,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic       state;
  logic [3:0] queues_in_use;

  ptr_t queue_head [MAX_QUEUES];
  ptr_t queue_tail [MAX_QUEUES];
  ptr_t free_head;

  word_t data_mem [STORE_DEPTH];
  ptr_t  link_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] link_valid;

  logic  cur_op;
  logic [2:0] cur_q;
  word_t cur_val;
  ptr_t  link_rd;
  ptr_t  link_dflt;
  logic  link_hit;
  word_t data_rd;

  logic  in_acc;
  logic  out_free;
  logic  done;
  ptr_t  rd_addr;
  ptr_t  link_val;
  ptr_t  cur_head;
  ptr_t  cur_tail;
  logic  invalid;
  logic  full;
  logic  empty;
  logic  enq_ok;
  logic  deq_ok;
  logic  link_we;
  ptr_t  link_wa;
  logic  data_we;
  status_t status_next;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign done     = (state == S_EXEC) && out_free;

  assign rd_addr  = (op == OP_DEQUEUE) ? queue_head[queue_number] : free_head;

  assign link_val = link_hit ? link_rd : link_dflt;
  assign cur_head = queue_head[cur_q];
  assign cur_tail = queue_tail[cur_q];
  assign invalid  = ({1'b0, cur_q} >= queues_in_use) || (int'(cur_q) >= MAX_QUEUES);
  assign full     = (free_head == NONE_PTR);
  assign empty    = (cur_head == NONE_PTR);
  assign enq_ok   = !invalid && (cur_op == OP_ENQUEUE) && !full;
  assign deq_ok   = !invalid && (cur_op == OP_DEQUEUE) && !empty;

  assign link_wa  = (cur_op == OP_DEQUEUE) ? cur_head : cur_tail;
  assign link_we  = done && (deq_ok || (enq_ok && !empty));
  assign data_we  = done && enq_ok;

  always_comb begin
    if (invalid) begin
      status_next = ST_INVALID;
    end else if (cur_op == OP_ENQUEUE) begin
      status_next = full ? ST_FULL : ST_OK;
    end else begin
      status_next = empty ? ST_EMPTY : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_op    <= op;
      cur_q     <= queue_number;
      cur_val   <= word_t'(value_in);
      link_rd   <= link_mem[rd_addr[ADDR_W-1:0]];
      link_hit  <= link_valid[rd_addr[ADDR_W-1:0]];
      link_dflt <= ptr_t'(rd_addr + ptr_t'(1));
      data_rd   <= data_mem[queue_head[queue_number][ADDR_W-1:0]];
    end
    if (link_we) begin
      link_mem[link_wa[ADDR_W-1:0]] <= free_head;
    end
    if (data_we) begin
      data_mem[free_head[ADDR_W-1:0]] <= cur_val;
    end
    if (done) begin
      value_out <= deq_ok ? data_rd : '0;
      status    <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      queues_in_use <= 4'd8;
      free_head     <= '0;
      link_valid    <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        queue_head[i] <= NONE_PTR;
        queue_tail[i] <= NONE_PTR;
      end
    end else begin
      if (cfg_we) begin
        queues_in_use <= cfg_data;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (link_we) begin
        link_valid[link_wa[ADDR_W-1:0]] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state <= S_IDLE;
            if (enq_ok) begin
              free_head         <= link_val;
              queue_tail[cur_q] <= free_head;
              if (empty) begin
                queue_head[cur_q] <= free_head;
              end
            end else if (deq_ok) begin
              free_head <= cur_head;
              if (cur_head == cur_tail) begin
                queue_head[cur_q] <= NONE_PTR;
                queue_tail[cur_q] <= NONE_PTR;
              end else begin
                queue_head[cur_q] <= link_val;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/sbmq_checker.sv
// ----------------------------------------------------------------------------
// Shared-buffer multi-queue checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module sbmq_checker
  import sbmq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               op,
  input logic [2:0]         queue_number,
  input logic signed [31:0] value_in,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] value_out,
  input logic [1:0]         status,
  input logic               cfg_we,
  input logic [3:0]         cfg_data
);

  a_reset_clears_out : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid after reset");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again in the cycle after a beat");

  a_value_zero_on_fail : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (value_out == '0))
    else $error("non-zero value on an unsuccessful result");

  a_out_held : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(value_out) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);
